>>> rtl/qed_pkg.sv
// Shared types and constants of the quake event detector.
package qed_pkg;

  localparam int unsigned MAG_W        = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned MEAN_W       = 24;
  localparam int unsigned VAR_W        = 32;
  localparam int unsigned SQ_W         = 64;
  localparam int unsigned OUT_CNT_W    = 24;
  localparam int unsigned RATE_W       = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned COUNT_BITS_D = 24;

  localparam logic [MAG_W-1:0]  THRESH_RST = 16'hFFFF;
  localparam logic [RATE_W-1:0] HOLDOFF_RST = 16'd5000;
  localparam logic [RATE_W-1:0] WINDOW_RST  = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_HOLDOFF   = 2'd1,
    CFG_WINDOW    = 2'd2
  } qed_cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MDIV_ST,
    S_MDIV_WT,
    S_MUL_ST,
    S_MUL_WT,
    S_VAR_ST,
    S_VAR_WT,
    S_FIN
  } qed_state_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } qed_ustat_t;

endpackage

>>> rtl/qed_if.sv
// Request channel interfaces: sample input, result output and register writes.
interface qed_in_if;
  import qed_pkg::*;
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  accel_magnitude;
  logic [TIME_W-1:0] now_ms;
  logic              clear_stats;
  modport source (output valid, accel_magnitude, now_ms, clear_stats, input ready);
  modport sink   (input valid, accel_magnitude, now_ms, clear_stats, output ready);
endinterface

interface qed_out_if;
  import qed_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 alert;
  logic                 in_event;
  logic                 over_threshold;
  logic                 sample_skipped;
  logic [MEAN_W-1:0]    running_mean;
  logic [VAR_W-1:0]     running_variance;
  logic [OUT_CNT_W-1:0] sample_count;
  logic [RATE_W-1:0]    probe_rate;
  modport source (output valid, alert, in_event, over_threshold, sample_skipped,
                  running_mean, running_variance, sample_count, probe_rate,
                  input ready);
  modport sink   (input valid, alert, in_event, over_threshold, sample_skipped,
                  running_mean, running_variance, sample_count, probe_rate,
                  output ready);
endinterface

interface qed_cfg_if;
  import qed_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/quake_event_detector_welford.sv
// Top level of the quake event detector with running mean and variance.
// Each sample request updates the rate window and event holdoff in the cycle it
// is accepted, then runs the statistics through bit-serial units: a divider for
// the mean step, a multiplier for the squared deviation and a 64-bit divider of
// the deviation sum by the count for the variance; a skipped sample runs only
// the variance divide, which is left out while the count is zero. A finished
// result waits in the output register while the next sample is accepted.
// Register writes are always ready.
module quake_event_detector_welford #(
  parameter int unsigned COUNT_BITS = qed_pkg::COUNT_BITS_D
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qed_in_if.sink    in_i,
  qed_out_if.source out_o,
  qed_cfg_if.sink   cfg_i
);
  import qed_pkg::*;

  // Configuration registers
  logic [MAG_W-1:0]  thresh_q;
  logic [RATE_W-1:0] holdoff_q, window_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= THRESH_RST;
      holdoff_q <= HOLDOFF_RST;
      window_q  <= WINDOW_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_THRESHOLD: thresh_q  <= cfg_i.data;
        CFG_HOLDOFF:   holdoff_q <= cfg_i.data;
        CFG_WINDOW:    window_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  qed_state_e state_q, state_d;

  logic                  ev_act_q;
  logic [TIME_W-1:0]     ev_start_q, win_start_q;
  logic [RATE_W-1:0]     win_cnt_q, rate_q;
  logic [MEAN_W-1:0]     mean_q, x_q, dmag_q, emag_q;
  logic [SQ_W-1:0]       sq_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  dneg_q, skip_q, alert_q, inev_q, over_q;
  logic [VAR_W-1:0]      var_q;

  logic out_vld_q;
  logic [MEAN_W-1:0]    o_mean_q;
  logic [VAR_W-1:0]     o_var_q;
  logic [OUT_CNT_W-1:0] o_cnt_q;
  logic [RATE_W-1:0]    o_rate_q;
  logic                 o_alert_q, o_inev_q, o_over_q, o_skip_q;

  logic in_acc, out_acc;
  logic mdiv_go, mul_go, vdiv_go, load_out;
  qed_ustat_t mdiv_st, mul_st, vdiv_st;
  logic [MEAN_W-1:0]   step;
  logic [VAR_W+VAR_W-1:0] vquot;
  logic [2*MEAN_W-1:0] prod;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  // Accept-cycle decisions: window, holdoff, threshold and deviation
  logic [TIME_W-1:0]     el_win, el_ev;
  logic                  win_done, expired, skip, over;
  logic [RATE_W-1:0]     win_inc;
  logic [MEAN_W-1:0]     mean_eff, x_in;
  logic [COUNT_BITS-1:0] cnt_eff, cnt_new;

  always_comb begin
    el_win   = in_i.now_ms - win_start_q;
    el_ev    = in_i.now_ms - ev_start_q;
    win_done = el_win > {{(TIME_W-RATE_W){1'b0}}, window_q};
    expired  = el_ev >= {{(TIME_W-RATE_W){1'b0}}, holdoff_q};
    win_inc  = (&win_cnt_q) ? win_cnt_q : win_cnt_q + 1'b1;
    skip     = ev_act_q && !expired;
    over     = !skip && (in_i.accel_magnitude > thresh_q);
    mean_eff = in_i.clear_stats ? '0 : mean_q;
    cnt_eff  = in_i.clear_stats ? '0 : cnt_q;
    cnt_new  = (&cnt_eff) ? cnt_eff : cnt_eff + 1'b1;
    x_in     = {in_i.accel_magnitude, {(MEAN_W-MAG_W){1'b0}}};
  end

  // Mean step completion
  logic [MEAN_W-1:0] new_mean;
  assign new_mean = dneg_q ? mean_q - step : mean_q + step;

  // Rounded deviation product and saturating sum
  logic [2*MEAN_W:0]   tsum;
  logic [SQ_W:0]       sq_sum;
  assign tsum   = {1'b0, prod} + (2*MEAN_W+1)'(16'h8000);
  assign sq_sum = {1'b0, sq_q} + (SQ_W+1)'(tsum[2*MEAN_W:16]);

  // Sequencer: next state and unit starts
  always_comb begin
    state_d  = state_q;
    mdiv_go  = 1'b0;
    mul_go   = 1'b0;
    vdiv_go  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = skip ? S_VAR_ST : S_MDIV_ST;
      S_MDIV_ST: begin
        mdiv_go = 1'b1;
        state_d = S_MDIV_WT;
      end
      S_MDIV_WT: if (mdiv_st.done) state_d = S_MUL_ST;
      S_MUL_ST:  begin
        mul_go  = 1'b1;
        state_d = S_MUL_WT;
      end
      S_MUL_WT:  if (mul_st.done) state_d = S_VAR_ST;
      S_VAR_ST:  begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          vdiv_go = 1'b1;
          state_d = S_VAR_WT;
        end
      end
      S_VAR_WT:  if (vdiv_st.done) state_d = S_FIN;
      S_FIN:     begin
        if (!out_vld_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Detector and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_act_q    <= 1'b0;
      ev_start_q  <= '0;
      win_start_q <= '0;
      win_cnt_q   <= '0;
      rate_q      <= '0;
      mean_q      <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_acc) begin
        if (win_done) begin
          rate_q      <= win_inc;
          win_cnt_q   <= '0;
          win_start_q <= in_i.now_ms;
        end else begin
          win_cnt_q <= win_inc;
        end
        if (!skip) begin
          ev_act_q <= over;
          if (over) ev_start_q <= in_i.now_ms;
          cnt_q <= cnt_new;
        end else begin
          cnt_q <= cnt_eff;
        end
        mean_q <= mean_eff;
        if (in_i.clear_stats) sq_q <= '0;
      end
      if (state_q == S_MDIV_WT && mdiv_st.done) mean_q <= new_mean;
      if (state_q == S_MUL_WT && mul_st.done) begin
        sq_q <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= x_in;
      dneg_q  <= x_in < mean_eff;
      dmag_q  <= (x_in < mean_eff) ? mean_eff - x_in : x_in - mean_eff;
      skip_q  <= skip;
      over_q  <= over;
      alert_q <= over;
      inev_q  <= skip || over;
    end
    if (state_q == S_MDIV_WT && mdiv_st.done) begin
      emag_q <= dneg_q ? new_mean - x_q : x_q - new_mean;
    end
    if (state_q == S_VAR_ST) var_q <= '0;
    if (state_q == S_VAR_WT && vdiv_st.done) begin
      var_q <= (|vquot[2*VAR_W-1:VAR_W]) ? '1 : vquot[VAR_W-1:0];
    end
  end

  // Mean step divider
  qed_sdiv #(.DW(MEAN_W), .VW(COUNT_BITS)) u_mdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mdiv_go),
    .dividend_i (dmag_q),
    .divisor_i  (cnt_q),
    .stat_o     (mdiv_st),
    .quot_o     (step)
  );

  // Deviation product
  qed_smul #(.W(MEAN_W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go),
    .mcand_i  (dmag_q),
    .mplier_i (emag_q),
    .stat_o   (mul_st),
    .prod_o   (prod)
  );

  // Variance divider
  qed_sdiv #(.DW(SQ_W), .VW(COUNT_BITS)) u_vdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (vdiv_go),
    .dividend_i (sq_q),
    .divisor_i  (cnt_q),
    .stat_o     (vdiv_st),
    .quot_o     (vquot)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (load_out) out_vld_q <= 1'b1;
    else if (out_acc) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_alert_q <= alert_q;
      o_inev_q  <= inev_q;
      o_over_q  <= over_q;
      o_skip_q  <= skip_q;
      o_mean_q  <= mean_q;
      o_var_q   <= var_q;
      o_cnt_q   <= OUT_CNT_W'(cnt_q);
      o_rate_q  <= rate_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.alert            = o_alert_q;
  assign out_o.in_event         = o_inev_q;
  assign out_o.over_threshold   = o_over_q;
  assign out_o.sample_skipped   = o_skip_q;
  assign out_o.running_mean     = o_mean_q;
  assign out_o.running_variance = o_var_q;
  assign out_o.sample_count     = o_cnt_q;
  assign out_o.probe_rate       = o_rate_q;

`ifndef SYNTHESIS
  a_mdiv_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdiv_st.done |-> state_q == S_MDIV_WT)
    else $error("mean divider finished outside its wait state");
  a_vdiv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdiv_st.busy |-> cnt_q != '0)
    else $error("variance divide running with zero count");
  a_skip_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.sample_skipped && out_o.over_threshold)
                    && (!out_o.alert || out_o.in_event))
    else $error("inconsistent event flags in result");
`endif

endmodule

>>> rtl/qed_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module qed_sdiv #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [VW-1:0]       divisor_i,
  output qed_pkg::qed_ustat_t stat_o,
  output logic [DW-1:0]       quot_o
);
  import qed_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [VW:0]   trial, diff;
  logic          ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

>>> rtl/qed_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module qed_smul #(
  parameter int unsigned W = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        mcand_i,
  input  logic [W-1:0]        mplier_i,
  output qed_pkg::qed_ustat_t stat_o,
  output logic [2*W-1:0]      prod_o
);
  import qed_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] acc_q;
  logic [W-1:0]   mcand_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [W:0]     sum;

  // Add the multiplicand under the current multiplier bit
  assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= {{W{1'b0}}, mplier_i};
      mcand_q <= mcand_i;
    end else if (run_q) begin
      acc_q <= {sum, acc_q[W-1:1]};
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

>>> verif/quake_event_detector_welford_tb.sv
// Self-checking testbench of the quake event detector with running statistics.
`timescale 1ns / 1ps

module quake_event_detector_welford_tb;
  import qed_pkg::*;

  localparam int unsigned CNT_MAX = (1 << COUNT_BITS_D) - 1;

  typedef struct packed {
    logic              alert;
    logic              in_event;
    logic              over;
    logic              skipped;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [OUT_CNT_W-1:0] count;
    logic [RATE_W-1:0] rate;
  } detect_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt = 0;
  bit   idle_on = 1'b1;

  qed_in_if  smp ();
  qed_out_if res ();
  qed_cfg_if cfg ();

  quake_event_detector_welford dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp.sink),
    .out_o  (res.source),
    .cfg_i  (cfg.sink)
  );

  always #10 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Scoreboard: detector state mirror and queue of expected results
  class detect_board;
    logic [15:0] thr = THRESH_RST;
    logic [15:0] hold = HOLDOFF_RST;
    logic [15:0] win = WINDOW_RST;
    bit          ev_act;
    logic [31:0] ev_start = '0;
    logic [15:0] win_cnt = '0;
    logic [31:0] win_start = '0;
    logic [15:0] rate_q = '0;
    logic [31:0] mean_q = '0;
    logic [63:0] sq_sum = '0;
    logic [31:0] n_cnt = '0;
    detect_res_t pending[$];

    function void write_reg(qed_cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_THRESHOLD: thr = v;
        CFG_HOLDOFF:   hold = v;
        default:       win = v;
      endcase
    endfunction

    function void note_sample(logic [15:0] acc, logic [31:0] now, bit clr);
      detect_res_t r;
      logic [31:0] x, n, dmag, emag, step, nm;
      logic [63:0] term, v;
      bit dneg;
      r = '0;
      if (clr) begin
        mean_q = '0; sq_sum = '0; n_cnt = '0;
      end
      if (win_cnt != 16'hFFFF) win_cnt++;
      if (now - win_start > {16'h0, win}) begin
        rate_q = win_cnt; win_cnt = '0; win_start = now;
      end
      if (ev_act) begin
        if (now - ev_start >= {16'h0, hold}) ev_act = 0;
        else r.skipped = 1;
      end
      if (!r.skipped) begin
        r.over = acc > thr;
        x = {8'h0, acc, 8'h0};
        if (n_cnt < CNT_MAX) n_cnt++;
        n = (n_cnt == '0) ? 32'd1 : n_cnt;
        dneg = x < mean_q;
        dmag = dneg ? mean_q - x : x - mean_q;
        step = dmag / n;
        nm = dneg ? mean_q - step : mean_q + step;
        emag = dneg ? nm - x : x - nm;
        mean_q = nm & 32'hFFFFFF;
        term = ({32'h0, dmag} * {32'h0, emag} + 64'h8000) >> 16;
        sq_sum = (sq_sum > ~64'h0 - term) ? ~64'h0 : sq_sum + term;
        if (r.over && !ev_act) begin
          ev_act = 1; ev_start = now; r.alert = 1;
        end
      end
      r.in_event = ev_act;
      r.mean = mean_q[23:0];
      if (n_cnt == '0) v = '0;
      else v = sq_sum / {32'h0, n_cnt};
      r.variance = (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
      r.count = n_cnt[23:0];
      r.rate = rate_q;
      pending.push_back(r);
    endfunction

    function string check_result(detect_res_t got);
      detect_res_t e;
      string s;
      if (pending.size() == 0) return "result with nothing pending";
      e = pending.pop_front();
      s = "";
      if (got.alert !== e.alert) s = {s, $sformatf(" alert %0b/%0b", got.alert, e.alert)};
      if (got.in_event !== e.in_event)
        s = {s, $sformatf(" in_event %0b/%0b", got.in_event, e.in_event)};
      if (got.over !== e.over) s = {s, $sformatf(" over %0b/%0b", got.over, e.over)};
      if (got.skipped !== e.skipped)
        s = {s, $sformatf(" skipped %0b/%0b", got.skipped, e.skipped)};
      if (got.mean !== e.mean) s = {s, $sformatf(" mean %h/%h", got.mean, e.mean)};
      if (got.variance !== e.variance)
        s = {s, $sformatf(" var %h/%h", got.variance, e.variance)};
      if (got.count !== e.count) s = {s, $sformatf(" count %h/%h", got.count, e.count)};
      if (got.rate !== e.rate) s = {s, $sformatf(" rate %h/%h", got.rate, e.rate)};
      return s;
    endfunction
  endclass

  detect_board board = new();
  logic [31:0] clock_ms = 0;

  initial begin
    smp.valid = 0; smp.accel_magnitude = 0; smp.now_ms = 0; smp.clear_stats = 0;
    cfg.valid = 0; cfg.index = CFG_THRESHOLD; cfg.data = 0;
    res.ready = 0;
  end

  // Random idle burst on the input side
  task automatic send_gap();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
  endtask

  // Drive one sample request and hold until accepted
  task automatic send_sample(logic [15:0] acc, logic [31:0] now, bit clr);
    send_gap();
    smp.valid = 1; smp.accel_magnitude = acc; smp.now_ms = now; smp.clear_stats = clr;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    board.note_sample(acc, now, clr);
    @(negedge clk_i);
    smp.valid = 0;
  endtask

  // Advance the time base and send a sample
  task automatic send_step(logic [15:0] acc, logic [31:0] dt, bit clr);
    clock_ms += dt;
    send_sample(acc, clock_ms, clr);
  endtask

  // Write one register
  task automatic write_reg(qed_cfg_idx_e idx, logic [15:0] v);
    cfg.valid = 1; cfg.index = idx; cfg.data = v;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    board.write_reg(idx, v);
    @(negedge clk_i);
    cfg.valid = 0;
  endtask

  // Wait until every pending result has arrived, then let the block settle
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // Result side: random stall bursts, check every accepted result
  initial begin
    detect_res_t got;
    string s;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res.ready = 0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      res.ready = 1;
      @(posedge clk_i);
      if (res.valid && res.ready && rst_ni) begin
        got = {res.alert, res.in_event, res.over_threshold, res.sample_skipped,
               res.running_mean, res.running_variance, res.sample_count, res.probe_rate};
        s = board.check_result(got);
        if (s != "") report(s);
      end
    end
  end

  // Random phase with one configuration setting
  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0: send_sample(16'($urandom), $urandom, $urandom_range(0, 1) == 1);
        1: send_step(16'($urandom), $urandom_range(0, 70000), $urandom_range(0, 7) == 0);
        2: send_step(16'($urandom_range(0, 15) << 12), 0, 0);
        default: send_step($urandom_range(0, 1) ? 16'($urandom)
                                                : 16'($urandom_range(0, 3000)),
                           $urandom_range(0, 1500), $urandom_range(0, 31) == 0);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed: reset settings, extremes, clear, wrap
    send_sample(16'h0000, 32'h0, 0);
    send_sample(16'hFFFF, 32'h0, 0);
    send_sample(16'hFFFF, 32'hFFFF_FFFF, 0);
    send_sample(16'h1234, 32'd1001, 1);
    drain();
    write_reg(CFG_THRESHOLD, 16'h2000);
    write_reg(CFG_HOLDOFF, 16'd100);
    write_reg(CFG_WINDOW, 16'd0);
    drain();
    clock_ms = 32'hFFFF_FFC0;
    send_step(16'h1000, 1, 0);
    send_step(16'h3000, 1, 0);       // event start
    send_step(16'h8000, 50, 1);      // skipped with clear
    send_step(16'hFFFF, 0, 0);
    send_step(16'h3000, 100, 0);     // holdoff ends across the wrap
    send_step(16'h2000, 0, 0);
    send_step(16'h2001, 200, 0);
    drain();
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_HOLDOFF, 16'd0);
    write_reg(CFG_THRESHOLD, 16'h0000);
    drain();
    send_step(16'h0001, 5, 0);
    send_step(16'h0001, 0, 0);
    send_step(16'h0000, 0, 1);
    drain();
    write_reg(CFG_HOLDOFF, 16'hFFFF);
    write_reg(CFG_WINDOW, 16'd1);
    drain();
    send_step(16'hFFFF, 2, 0);
    send_step(16'h0000, 1, 0);
    drain();
    // Random phases through several settings
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_THRESHOLD, (p == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_HOLDOFF, (p == 1) ? 16'd0 : 16'($urandom_range(0, 4000)));
      write_reg(CFG_WINDOW, (p == 2) ? 16'd1 : 16'($urandom_range(1, 3000)));
      random_phase(70);
      drain();
    end
    idle_on = 0;
    random_phase(60);
    drain();
    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/qed_pkg.sv
rtl/qed_if.sv
rtl/qed_sdiv.sv
rtl/qed_smul.sv
rtl/quake_event_detector_welford.sv
verif/quake_event_detector_welford_tb.sv
